### sv/ncpt_pkg.sv
// Shared types and constants for the network card paging and trap port logic.
// No dependencies. Used by the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package ncpt_pkg;

  // Transaction kinds on the request channel
  typedef enum logic [2:0] {
    MODE_IO_WRITE  = 3'd0,
    MODE_IO_READ   = 3'd1,
    MODE_NMI       = 3'd2,
    MODE_RETN      = 3'd3,
    MODE_WIN_READ  = 3'd4,
    MODE_WIN_WRITE = 3'd5,
    MODE_RSVD6     = 3'd6,
    MODE_RSVD7     = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PAGE_IN  = 2'd1,
    EV_PAGE_OUT = 2'd2,
    EV_RSVD     = 2'd3
  } page_event_t;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_NET_REGS = 3'd1,
    TGT_FILE_SYS = 3'd2,
    TGT_SETTINGS = 3'd3,
    TGT_FLASH    = 3'd4
  } target_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILE_SYS_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTINGS_PAGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_BANKED    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_UNPAGED = 2'd3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration reset values
  localparam logic [7:0] FILE_SYS_PAGE_RST = 8'd72;
  localparam logic [7:0] SETTINGS_PAGE_RST = 8'd73;
  localparam logic       HAS_BANKED_RST    = 1'b1;
  localparam logic       START_UNPAGED_RST = 1'b0;

  // I/O ports, fully decoded
  localparam logic [15:0] PORT_PAGE_A  = 16'h003b;
  localparam logic [15:0] PORT_PAGE_B  = 16'h013b;
  localparam logic [15:0] PORT_TRAP    = 16'h023b;
  localparam logic [15:0] PORT_CONTROL = 16'h033b;

  localparam logic [7:0] LOGIC_VERSION = 8'h03;
  localparam logic [7:0] NO_MATCH_DATA = 8'hff;
  localparam logic [7:0] PAGE_RST      = 8'hff;
  localparam logic [4:0] NET_PAGE_HI   = 5'b01000; // pages 0x40..0x47
  localparam logic [2:0] FLASH_PAGE_HI = 3'b000;   // pages below 0x20

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] port;
    logic [7:0]  data;
    logic [15:0] mem_address;
    logic [2:0]  border_bits;
    logic        bank_select_bit;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        port_matched;
    logic        paged;
    logic        paged_by_io;
    logic [1:0]  paging_event;
    logic        nmi_suppressed;
    logic [15:0] trap_address;
    logic        trap_enabled;
    logic [2:0]  access_target;
    logic [14:0] target_address;
    logic [2:0]  flash_bank;
  } rsp_t;

endpackage

`default_nettype wire

### sv/ncpt_stream_if.sv
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is supplied at instantiation (see ncpt_pkg for req_t / rsp_t).
`timescale 1ns / 1ps
`default_nettype none

interface ncpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### sv/network_card_paging_and_trap_ports_top.sv
// Paging and trap port logic of the network expansion card, top level.
// Depends on ncpt_pkg and ncpt_stream_if.
`timescale 1ns / 1ps
`default_nettype none

// One request transaction (I/O write/read, NMI, RETN, window read/write) gives
// exactly one response transaction. A request is captured in an input
// register, then the port decode, paging flags, trap loader and window
// router all resolve in one pass of combinational logic and the result lands
// in the output register once it is free, so a new request is taken every
// cycle while the output side keeps up. The state update of one
// request is done before the next one is evaluated, so back-to-back requests
// see each other's effects in order. Response fields describe the state after
// the request. Configuration writes (file-system page, settings page, banked
// memory flag, start-unpaged) are taken on cfg_we and must only be issued while
// no request is in flight. Writes of start_unpaged are ignored: reset always
// uses its default, so the card comes out of reset paged in.
module network_card_paging_and_trap_ports_top (
  input  wire                              clk,
  input  wire                              rst,
  ncpt_stream_if.sink                      req,
  ncpt_stream_if.source                    rsp,
  input  wire                              cfg_we,
  input  wire [ncpt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [ncpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ncpt_pkg::*;

  // ---------------- configuration ----------------
  logic [7:0] file_system_page;
  logic [7:0] settings_page;
  logic       has_banked_memory;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_system_page  <= FILE_SYS_PAGE_RST;
      settings_page     <= SETTINGS_PAGE_RST;
      has_banked_memory <= HAS_BANKED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FILE_SYS_PAGE: file_system_page  <= cfg_data;
        CFG_SETTINGS_PAGE: settings_page     <= cfg_data;
        CFG_HAS_BANKED:    has_banked_memory <= cfg_data[0];
        // ignored on write; reset always uses its default value
        CFG_START_UNPAGED: ;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid;
  req_t s1;
  logic s1_adv;
  logic out_valid;
  rsp_t out_data;

  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.payload;
    end
  end

  // ---------------- architectural state ----------------
  logic [7:0]  window_a_page, window_a_page_next;
  logic [7:0]  window_b_page, window_b_page_next;
  logic        paged_flag, paged_flag_next;
  logic        io_paged_flag, io_paged_flag_next;
  logic [15:0] trap_register, trap_register_next;
  logic        trap_enable, trap_enable_next;
  logic        trap_high_next, trap_high_next_next;
  logic        nmi_flip_flop, nmi_flip_flop_next;

  rsp_t  result;
  mode_t mode;
  logic  in_window;
  logic [7:0] win_page;
  logic  trap_wr;

  assign mode = mode_t'(s1.mode);
  // 0x1000..0x2fff
  assign in_window = (s1.mem_address[15:14] == 2'b00) &&
                     (s1.mem_address[13] != s1.mem_address[12]);
  assign win_page  = (s1.mem_address[13:12] == 2'b01) ? window_a_page : window_b_page;
  assign trap_wr   = (mode == MODE_IO_WRITE) && (s1.port == PORT_TRAP);

  always_comb begin
    page_event_t ev;
    target_t     tgt;
    logic [7:0]  rd;
    logic        matched;
    logic [14:0] taddr;
    logic [2:0]  fbank;

    window_a_page_next  = window_a_page;
    window_b_page_next  = window_b_page;
    paged_flag_next     = paged_flag;
    io_paged_flag_next  = io_paged_flag;
    trap_register_next  = trap_register;
    trap_enable_next    = trap_enable;
    trap_high_next_next = trap_high_next;
    nmi_flip_flop_next  = nmi_flip_flop;

    ev      = EV_NONE;
    tgt     = TGT_NONE;
    rd      = NO_MATCH_DATA;
    matched = 1'b0;
    taddr   = '0;
    fbank   = '0;

    unique case (mode)
      MODE_IO_WRITE: begin
        matched = 1'b1;
        priority if (s1.port == PORT_PAGE_A) begin
          window_a_page_next = s1.data;
        end else if (s1.port == PORT_PAGE_B) begin
          window_b_page_next = s1.data;
        end else if (s1.port == PORT_TRAP) begin
          if (trap_high_next) begin
            trap_register_next = {s1.data, trap_register[7:0]};
          end else begin
            trap_register_next = {trap_register[15:8], s1.data};
          end
          trap_high_next_next = ~trap_high_next;
        end else if (s1.port == PORT_CONTROL) begin
          if (s1.data[0]) begin
            if (!paged_flag) begin
              paged_flag_next    = 1'b1;
              io_paged_flag_next = 1'b1;
              ev                 = EV_PAGE_IN;
            end
          end else if (io_paged_flag && paged_flag) begin
            paged_flag_next    = 1'b0;
            io_paged_flag_next = 1'b0;
            ev                 = EV_PAGE_OUT;
          end
          trap_enable_next = s1.data[3];
        end else begin
          matched = 1'b0;
        end
      end
      MODE_IO_READ: begin
        if (s1.port == PORT_TRAP) begin
          matched = 1'b1;
          rd      = LOGIC_VERSION;
        end else if (s1.port == PORT_CONTROL) begin
          matched = 1'b1;
          rd      = {3'b000, has_banked_memory & s1.bank_select_bit, trap_enable,
                     s1.border_bits};
        end
      end
      MODE_NMI: begin
        nmi_flip_flop_next = 1'b1;
        if (!paged_flag) begin
          paged_flag_next    = 1'b1;
          io_paged_flag_next = 1'b0;
          ev                 = EV_PAGE_IN;
        end
      end
      MODE_RETN: begin
        nmi_flip_flop_next = 1'b0;
      end
      MODE_WIN_READ, MODE_WIN_WRITE: begin
        if (paged_flag && in_window) begin
          priority if (win_page[7:3] == NET_PAGE_HI) begin
            tgt   = TGT_NET_REGS;
            taddr = {win_page[2:0], s1.mem_address[11:0]};
          end else if (win_page == file_system_page) begin
            tgt = TGT_FILE_SYS;
          end else if (win_page == settings_page) begin
            tgt = TGT_SETTINGS;
          end else if (mode == MODE_WIN_WRITE && window_b_page[7:5] == FLASH_PAGE_HI) begin
            tgt   = TGT_FLASH;
            fbank = window_b_page[4:2];
            taddr = {1'b0, window_b_page[1:0], s1.mem_address[11:0]};
          end else begin
            tgt = TGT_NONE;
          end
        end
      end
      default: ; // reserved modes: no effect
    endcase

    result.read_data      = rd;
    result.port_matched   = matched;
    result.paged          = paged_flag_next;
    result.paged_by_io    = io_paged_flag_next;
    result.paging_event   = ev;
    result.nmi_suppressed = nmi_flip_flop_next;
    result.trap_address   = trap_register_next;
    result.trap_enabled   = trap_enable_next;
    result.access_target  = tgt;
    result.target_address = taddr;
    result.flash_bank     = fbank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_a_page  <= PAGE_RST;
      window_b_page  <= PAGE_RST;
      paged_flag     <= ~START_UNPAGED_RST;
      io_paged_flag  <= 1'b0;
      trap_register  <= '0;
      trap_enable    <= 1'b0;
      trap_high_next <= 1'b0;
      nmi_flip_flop  <= 1'b0;
    end else if (s1_adv) begin
      window_a_page  <= window_a_page_next;
      window_b_page  <= window_b_page_next;
      paged_flag     <= paged_flag_next;
      io_paged_flag  <= io_paged_flag_next;
      trap_register  <= trap_register_next;
      trap_enable    <= trap_enable_next;
      trap_high_next <= trap_high_next_next;
      nmi_flip_flop  <= nmi_flip_flop_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data <= result;
    end
  end

  // ---------------- assertions ----------------
  // I/O paging flag never outlives paging itself
  a_io_implies_paged: assert property (@(posedge clk) disable iff (rst)
    io_paged_flag |-> paged_flag)
    else $error("io_paged_flag set while card is paged out");

  // a page-in event always reports the card paged
  a_pagein_paged: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.paging_event == EV_PAGE_IN) |-> out_data.paged)
    else $error("page-in event without paged");

  // flash bank only meaningful for flash target
  a_bank_only_flash: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.access_target != TGT_FLASH) |-> (out_data.flash_bank == 3'd0))
    else $error("flash_bank nonzero for non-flash target");

  // trap byte toggle flips exactly on a trap port write
  a_trap_toggle: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && trap_wr) |=> (trap_high_next != $past(trap_high_next)))
    else $error("trap byte toggle did not flip");

  // read data other than the idle value only comes from a matched port
  a_read_matched: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_data != NO_MATCH_DATA) |-> out_data.port_matched)
    else $error("read data without port match");

endmodule

`default_nettype wire

### tb/tb_network_card_paging_and_trap_ports_top.sv
// Self-checking testbench for network_card_paging_and_trap_ports_top: drives
// port, event and window transactions and checks each response against a model.
// Depends on ncpt_pkg and ncpt_stream_if.
`timescale 1ns / 1ps

module tb_network_card_paging_and_trap_ports_top;
  import ncpt_pkg::*;

  // Requests pass the input register and the output register before they come out.
  localparam int unsigned PIPE_LATENCY     = 2;
  // Cycles with no transaction on either channel before the run is called dead.
  localparam int unsigned WATCHDOG_LIMIT   = 1000;
  // Long receiver hold-off: far longer than the block can buffer.
  localparam int unsigned LONG_HOLD_CYCLES = 48;

  localparam logic [15:0] WINDOW_A_BASE    = 16'h1000;
  localparam logic [15:0] WINDOW_B_BASE    = 16'h2000;
  localparam logic [15:0] WINDOW_END       = 16'h3000;
  localparam logic [15:0] WINDOW_OFS_MASK  = 16'h0fff;
  localparam logic [7:0]  NET_FIRST_PAGE   = 8'h40;
  localparam logic [7:0]  NET_LAST_PAGE    = 8'h47;
  localparam logic [7:0]  FLASH_PAGE_LIMIT = 8'h20;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ncpt_stream_if #(.payload_t(req_t)) req_ch ();
  ncpt_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  network_card_paging_and_trap_ports_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Model of the card: configuration copy and paging/trap state.
  // start_unpaged only acts at reset, and reset happens once with the default.
  // ---------------------------------------------------------------------------
  logic [7:0]  cfg_fs_page       = FILE_SYS_PAGE_RST;
  logic [7:0]  cfg_settings_page = SETTINGS_PAGE_RST;
  logic        cfg_has_banked    = HAS_BANKED_RST;
  logic        cfg_start_unpaged = START_UNPAGED_RST;

  logic [7:0]  card_win_a_page   = PAGE_RST;
  logic [7:0]  card_win_b_page   = PAGE_RST;
  logic        card_paged        = !START_UNPAGED_RST;
  logic        card_paged_by_io  = 1'b0;
  logic [15:0] card_trap_addr    = 16'h0000;
  logic        card_trap_en      = 1'b0;
  logic        card_trap_hi_next = 1'b0;
  logic        card_nmi_ff       = 1'b0;

  rsp_t pending_card_responses[$];

  int unsigned failures          = 0;
  int unsigned requests_sent     = 0;
  int unsigned responses_checked = 0;
  int unsigned settings_applied  = 0;

  // Idling knobs for sender and receiver; idle_enabled acts on both.
  bit          idle_enabled      = 1'b1;
  bit          long_hold_active  = 1'b0;
  int unsigned hold_count        = 0;
  int unsigned ready_stall_left  = 0;

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Response side: random stall bursts, plus one long hold-off requested by a
  // test and counted down here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (long_hold_active) begin
      rsp_ch.ready <= 1'b0;
      hold_count++;
      if (hold_count >= LONG_HOLD_CYCLES) begin
        hold_count       = 0;
        long_hold_active = 1'b0;
      end
    end else if (ready_stall_left != 0) begin
      rsp_ch.ready <= 1'b0;
      ready_stall_left--;
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      rsp_ch.ready <= 1'b0;
      ready_stall_left = $urandom_range(0, 4);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: responses are checked before the request of the same edge is
  // predicted; a response can never belong to a request accepted that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready)
        check_card_response(rsp_ch.payload);
      if (req_ch.valid && req_ch.ready)
        pending_card_responses.push_back(predict_card_response(req_ch.payload));
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles in which neither channel moves a transaction.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no transaction for %0d cycles, %0d responses outstanding",
           WATCHDOG_LIMIT, pending_card_responses.size());
    $display("network_card_paging_and_trap_ports_top: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one request to the model state and returns the
  // response, which reports the state after the request.
  // ---------------------------------------------------------------------------
  function automatic rsp_t predict_card_response(input req_t r);
    rsp_t        p;
    logic [7:0]  page;
    p              = '0;
    p.read_data    = NO_MATCH_DATA;
    p.paging_event = EV_NONE;
    p.access_target = TGT_NONE;
    case (mode_t'(r.mode))
      MODE_IO_WRITE: begin
        p.port_matched = 1'b1;
        case (r.port)
          PORT_PAGE_A: card_win_a_page = r.data;
          PORT_PAGE_B: card_win_b_page = r.data;
          PORT_TRAP: begin
            // low byte first, then high byte, by a toggle
            if (card_trap_hi_next)
              card_trap_addr[15:8] = r.data;
            else
              card_trap_addr[7:0] = r.data;
            card_trap_hi_next = ~card_trap_hi_next;
          end
          PORT_CONTROL: begin
            if (r.data[0]) begin
              if (!card_paged) begin
                card_paged       = 1'b1;
                card_paged_by_io = 1'b1;
                p.paging_event   = EV_PAGE_IN;
              end
            end else if (card_paged_by_io && card_paged) begin
              // only paging that came through this port is undone here
              card_paged       = 1'b0;
              card_paged_by_io = 1'b0;
              p.paging_event   = EV_PAGE_OUT;
            end
            card_trap_en = r.data[3];
          end
          default: p.port_matched = 1'b0;
        endcase
      end
      MODE_IO_READ: begin
        if (r.port == PORT_TRAP) begin
          p.port_matched = 1'b1;
          p.read_data    = LOGIC_VERSION;
        end else if (r.port == PORT_CONTROL) begin
          p.port_matched = 1'b1;
          p.read_data    = {3'b000, cfg_has_banked & r.bank_select_bit, card_trap_en,
                            r.border_bits};
        end
      end
      MODE_NMI: begin
        card_nmi_ff = 1'b1;
        if (!card_paged) begin
          card_paged       = 1'b1;
          card_paged_by_io = 1'b0;
          p.paging_event   = EV_PAGE_IN;
        end
      end
      MODE_RETN: card_nmi_ff = 1'b0;
      MODE_WIN_READ, MODE_WIN_WRITE: begin
        if (card_paged && r.mem_address >= WINDOW_A_BASE && r.mem_address < WINDOW_END) begin
          page = (r.mem_address < WINDOW_B_BASE) ? card_win_a_page : card_win_b_page;
          if (page >= NET_FIRST_PAGE && page <= NET_LAST_PAGE) begin
            p.access_target  = TGT_NET_REGS;
            p.target_address = {page[2:0], r.mem_address[11:0]};
          end else if (page == cfg_fs_page) begin
            p.access_target = TGT_FILE_SYS;
          end else if (page == cfg_settings_page) begin
            p.access_target = TGT_SETTINGS;
          end else if (r.mode == MODE_WIN_WRITE && card_win_b_page < FLASH_PAGE_LIMIT) begin
            // flash is always addressed through the window B page
            p.access_target  = TGT_FLASH;
            p.flash_bank     = card_win_b_page[4:2];
            p.target_address = {1'b0, card_win_b_page[1:0], r.mem_address[11:0]};
          end
        end
      end
      default: ;
    endcase
    p.paged          = card_paged;
    p.paged_by_io    = card_paged_by_io;
    p.nmi_suppressed = card_nmi_ff;
    p.trap_address   = card_trap_addr;
    p.trap_enabled   = card_trap_en;
    return p;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  task automatic check_card_response(input rsp_t got);
    rsp_t want;
    if (pending_card_responses.size() == 0) begin
      $error("response transaction with nothing expected: %p", got);
      failures++;
    end else begin
      want = pending_card_responses.pop_front();
      responses_checked++;
      compare_field("read_data",      want.read_data,      got.read_data);
      compare_field("port_matched",   want.port_matched,   got.port_matched);
      compare_field("paged",          want.paged,          got.paged);
      compare_field("paged_by_io",    want.paged_by_io,    got.paged_by_io);
      compare_field("paging_event",   want.paging_event,   got.paging_event);
      compare_field("nmi_suppressed", want.nmi_suppressed, got.nmi_suppressed);
      compare_field("trap_address",   want.trap_address,   got.trap_address);
      compare_field("trap_enabled",   want.trap_enabled,   got.trap_enabled);
      compare_field("access_target",  want.access_target,  got.access_target);
      compare_field("target_address", want.target_address, got.target_address);
      compare_field("flash_bank",     want.flash_bank,     got.flash_bank);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic req_t random_request();
    req_t r;
    r.mode            = 3'($urandom);
    r.port            = 16'($urandom);
    r.data            = 8'($urandom);
    r.mem_address     = 16'($urandom);
    r.border_bits     = 3'($urandom);
    r.bank_select_bit = 1'($urandom);
    return r;
  endfunction

  // Fields that the mode ignores stay random so every bit moves.
  function automatic req_t make_request(input mode_t m, input logic [15:0] port,
                                        input logic [7:0] data, input logic [15:0] addr);
    req_t r;
    r             = random_request();
    r.mode        = m;
    r.port        = port;
    r.data        = data;
    r.mem_address = addr;
    return r;
  endfunction

  function automatic logic [15:0] pick_card_port();
    case ($urandom_range(0, 3))
      0:       return PORT_PAGE_A;
      1:       return PORT_PAGE_B;
      2:       return PORT_TRAP;
      default: return PORT_CONTROL;
    endcase
  endfunction

  // Pages that hit each routing rule, with neighbors of the network range.
  function automatic logic [7:0] pick_window_page();
    case ($urandom_range(0, 5))
      0:       return NET_FIRST_PAGE + 8'($urandom_range(0, 7));
      1:       return cfg_fs_page;
      2:       return cfg_settings_page;
      3:       return 8'($urandom_range(0, FLASH_PAGE_LIMIT - 1));
      4:       return 8'($urandom_range(FLASH_PAGE_LIMIT, 8'h4f));
      default: return 8'($urandom);
    endcase
  endfunction

  // Called on a clock edge. valid stays high on return; stop_requests lowers
  // it, so valid never gets two assignments in one step.
  task automatic send_request(input req_t r);
    int unsigned gap;
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic stop_requests();
    req_ch.valid <= 1'b0;
  endtask

  // One edge first so the monitor has queued the last accepted request.
  task automatic wait_for_idle();
    stop_requests();
    @(posedge clk);
    while (pending_card_responses.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Only called while idle; the model copy is updated once the DUT has it.
  task automatic apply_settings(input logic [7:0] fs_page, input logic [7:0] set_page,
                                input logic banked, input logic unpaged);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FILE_SYS_PAGE;
    cfg_data  <= fs_page;
    @(posedge clk);
    cfg_index <= CFG_SETTINGS_PAGE;
    cfg_data  <= set_page;
    @(posedge clk);
    cfg_index <= CFG_HAS_BANKED;
    cfg_data  <= {7'b0, banked};
    @(posedge clk);
    cfg_index <= CFG_START_UNPAGED;
    cfg_data  <= {7'b0, unpaged};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_fs_page       = fs_page;
    cfg_settings_page = set_page;
    cfg_has_banked    = banked;
    cfg_start_unpaged = unpaged;
    settings_applied++;
  endtask

  // Mostly well-formed sequences (map a window then use it, trap loads,
  // control write then status read, NMI/RETN brackets), some noise.
  task automatic run_card_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned n;
    logic [15:0] base;
    logic [7:0]  ctrl;
    req_t        r;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        base = $urandom_range(0, 1) ? WINDOW_B_BASE : WINDOW_A_BASE;
        send_request(make_request(MODE_IO_WRITE,
                                  (base == WINDOW_A_BASE) ? PORT_PAGE_A : PORT_PAGE_B,
                                  pick_window_page(), 16'($urandom)));
        n = $urandom_range(1, 4);
        repeat (n)
          send_request(make_request($urandom_range(0, 1) ? MODE_WIN_WRITE : MODE_WIN_READ,
                                    16'($urandom), 8'($urandom),
                                    base | (16'($urandom) & WINDOW_OFS_MASK)));
        sent += n + 1;
      end else if (kind < 45) begin
        n = $urandom_range(1, 2);
        repeat (n)
          send_request(make_request(MODE_IO_WRITE, PORT_TRAP, 8'($urandom), 16'($urandom)));
        sent += n;
      end else if (kind < 57) begin
        ctrl = 8'($urandom);
        if ($urandom_range(0, 3) != 0) ctrl[0] = 1'b1;
        send_request(make_request(MODE_IO_WRITE, PORT_CONTROL, ctrl, 16'($urandom)));
        send_request(make_request(MODE_IO_READ, PORT_CONTROL, 8'($urandom), 16'($urandom)));
        sent += 2;
      end else if (kind < 67) begin
        send_request(make_request(MODE_NMI, 16'($urandom), 8'($urandom), 16'($urandom)));
        n = $urandom_range(0, 3);
        repeat (n)
          send_request(make_request(MODE_WIN_READ, 16'($urandom), 8'($urandom),
                                    16'($urandom_range(WINDOW_A_BASE, WINDOW_END - 1))));
        send_request(make_request(MODE_RETN, 16'($urandom), 8'($urandom), 16'($urandom)));
        sent += n + 2;
      end else if (kind < 80) begin
        send_request(make_request(MODE_IO_READ, pick_card_port(), 8'($urandom),
                                  16'($urandom)));
        sent++;
      end else if (kind < 92) begin
        // noise: any mode, random or near-miss port numbers
        r = random_request();
        if ($urandom_range(0, 1))
          r.port = pick_card_port() ^ (16'h0001 << $urandom_range(0, 15));
        send_request(r);
        sent++;
      end else begin
        send_request(make_request($urandom_range(0, 1) ? MODE_WIN_WRITE : MODE_WIN_READ,
                                  16'($urandom), 8'($urandom), 16'($urandom)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Port decode, every mode, each routing rule and the window edges,
  // all under the reset configuration.
  task automatic test_directed_ports_and_windows();
    req_t r;
    send_request(make_request(MODE_IO_READ, PORT_TRAP, 8'h00, 16'h0000));
    r = make_request(MODE_IO_READ, PORT_CONTROL, 8'hff, 16'hffff);
    r.border_bits     = 3'h7;
    r.bank_select_bit = 1'b1;
    send_request(r);
    // page ports do not answer reads
    send_request(make_request(MODE_IO_READ, PORT_PAGE_A, 8'h00, 16'h0000));
    send_request(make_request(MODE_IO_WRITE, 16'hffff, 8'hff, 16'hffff));
    send_request(make_request(MODE_IO_WRITE, PORT_PAGE_A, NET_FIRST_PAGE, 16'h0000));
    send_request(make_request(MODE_IO_WRITE, PORT_PAGE_B, NET_LAST_PAGE, 16'h0000));
    send_request(make_request(MODE_WIN_READ, 16'h0000, 8'h00, WINDOW_A_BASE));
    send_request(make_request(MODE_WIN_WRITE, 16'hffff, 8'hff, WINDOW_END - 1));
    // just outside both windows
    send_request(make_request(MODE_WIN_READ, 16'h0000, 8'h00, WINDOW_A_BASE - 1));
    send_request(make_request(MODE_WIN_WRITE, 16'h0000, 8'h00, WINDOW_END));
    send_request(make_request(MODE_IO_WRITE, PORT_PAGE_A, cfg_fs_page, 16'h0000));
    send_request(make_request(MODE_WIN_WRITE, 16'h0000, 8'h5a, WINDOW_B_BASE - 1));
    send_request(make_request(MODE_IO_WRITE, PORT_PAGE_B, cfg_settings_page, 16'h0000));
    send_request(make_request(MODE_WIN_READ, 16'h0000, 8'h00, WINDOW_B_BASE));
    // top flash page, then a read of it goes to plain memory
    send_request(make_request(MODE_IO_WRITE, PORT_PAGE_B, FLASH_PAGE_LIMIT - 1, 16'h0000));
    send_request(make_request(MODE_WIN_WRITE, 16'h0000, 8'ha5, 16'h2abc));
    send_request(make_request(MODE_WIN_READ, 16'h0000, 8'h00, 16'h2abc));
    send_request(make_request(MODE_IO_WRITE, PORT_TRAP, 8'h34, 16'h0000));
    send_request(make_request(MODE_IO_WRITE, PORT_TRAP, 8'h12, 16'h0000));
    send_request(make_request(MODE_IO_WRITE, PORT_CONTROL, 8'h08, 16'h0000));
    r = make_request(MODE_IO_READ, PORT_CONTROL, 8'h00, 16'h0000);
    r.border_bits     = 3'h0;
    r.bank_select_bit = 1'b0;
    send_request(r);
    // already paged: no event, paging not claimed by the port
    send_request(make_request(MODE_IO_WRITE, PORT_CONTROL, 8'h01, 16'h0000));
    send_request(make_request(MODE_NMI, 16'h0000, 8'h00, 16'h0000));
    send_request(make_request(MODE_RETN, 16'h0000, 8'h00, 16'h0000));
    send_request(make_request(MODE_RSVD6, PORT_CONTROL, 8'hff, WINDOW_A_BASE));
    send_request(make_request(MODE_RSVD7, PORT_TRAP, 8'hff, WINDOW_B_BASE));
  endtask

  // Several register settings including both extremes; each followed by traffic.
  task automatic test_register_settings();
    wait_for_idle();
    apply_settings(8'h00, 8'hff, 1'b0, 1'b1);
    run_card_traffic(150);
    wait_for_idle();
    apply_settings(8'hff, 8'h00, 1'b1, 1'b0);
    run_card_traffic(150);
    // same page for both: file system wins, and both shadow flash pages
    wait_for_idle();
    apply_settings(8'h10, 8'h10, 1'b0, 1'b0);
    run_card_traffic(150);
    // network pages take priority over a file-system page in their range
    wait_for_idle();
    apply_settings(8'h43, FLASH_PAGE_LIMIT - 1, 1'b1, 1'b1);
    run_card_traffic(150);
    wait_for_idle();
    apply_settings(8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
    run_card_traffic(150);
    wait_for_idle();
    apply_settings(FILE_SYS_PAGE_RST, SETTINGS_PAGE_RST, HAS_BANKED_RST, START_UNPAGED_RST);
  endtask

  // Receiver holds off long enough for the block to fill and stall requests.
  task automatic test_output_backpressure();
    long_hold_active = 1'b1;
    run_card_traffic(40);
    while (long_hold_active) @(posedge clk);
  endtask

  // Sender stops until every response is back, then resumes.
  task automatic test_drain_pause();
    run_card_traffic(30);
    wait_for_idle();
    run_card_traffic(30);
  endtask

  task automatic test_random_traffic();
    run_card_traffic(600);
  endtask

  // Last stretch runs back to back on both sides.
  task automatic test_unthrottled_traffic();
    wait_for_idle();
    idle_enabled = 1'b0;
    run_card_traffic(150);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    rst            <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed_ports_and_windows();
    test_register_settings();
    test_output_backpressure();
    test_drain_pause();
    test_random_traffic();
    test_unthrottled_traffic();

    wait_for_idle();
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (pending_card_responses.size() != 0) begin
      $error("%0d expected responses never arrived", pending_card_responses.size());
      failures++;
    end

    $display("run covered %0d requests and %0d checked responses over %0d register settings,",
             requests_sent, responses_checked, settings_applied + 1);
    $display("with a long output stall, a full drain pause and a back-to-back stretch");
    if (failures == 0) begin
      $display("network_card_paging_and_trap_ports_top: match");
    end else begin
      $display("network_card_paging_and_trap_ports_top: mismatch");
    end
    $finish;
  end

endmodule
